// File: hw/rtl/sbuod_pkg.sv
// ----------------------------------------------------------------------------
// sbuod_pkg: shared types and constants for the sideband orientation detector
// Line pattern codes, change event codes, register indexes and count limits.
// ----------------------------------------------------------------------------
`default_nettype none

package sbuod_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 4;
	localparam int CFG_IDX_W = 2;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [1:0]          pattern_t;
	typedef logic [1:0]          event_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// line patterns
	localparam pattern_t PAT_DISCONNECT = 2'd0;
	localparam pattern_t PAT_DIRECT     = 2'd1;
	localparam pattern_t PAT_FLIP       = 2'd2;
	localparam pattern_t PAT_OTHER      = 2'd3;

	// change events
	localparam event_t EV_NONE       = 2'd0;
	localparam event_t EV_CONNECT    = 2'd1;
	localparam event_t EV_DISCONNECT = 2'd2;

	// register indexes
	localparam cfg_idx_t REG_LOW_THRESHOLD  = 2'd0;
	localparam cfg_idx_t REG_HIGH_THRESHOLD = 2'd1;
	localparam cfg_idx_t REG_SETTLE_POLLS   = 2'd2;

	localparam count_t  COUNT_MAX       = 4'd15;
	localparam sample_t LOW_THR_RESET   = 16'd0;
	localparam sample_t HIGH_THR_RESET  = 16'hFFFF;
	localparam count_t  SETTLE_RESET    = 4'd5;

	localparam logic ORIENT_FLIPPED = 1'b0;
	localparam logic ORIENT_DIRECT  = 1'b1;

endpackage

`default_nettype wire

// File: hw/rtl/sbu_orientation_detector.sv
// ----------------------------------------------------------------------------
// sbu_orientation_detector: sideband line orientation detector
// Debounces connect / disconnect patterns on two sideband line samples and
// drives the mux enable and orientation select.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+-------------------------------------
//   in      | in  | in_valid / in_stall    | line1_sample, line2_sample, sample_error
//   out     | out | out_valid / out_stall  | mux_enable, mux_select, change_event,
//           |     |                        | poll_ignored
//   cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word in, one word out, one word per cycle sustained unless the output is
// stalled. A word moves through an input register, then compare and state update
// into the result register. Reset clears tracking state, loads register defaults.
// A stalled output holds its word; the input stalls only when both the
// input register and the result register hold words and the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sbu_orientation_detector (
	input  wire                           clk,
	input  wire                           arst_n,
	// poll words
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  sbuod_pkg::sample_t      line1_sample,
	input  wire  sbuod_pkg::sample_t      line2_sample,
	input  wire                           sample_error,
	// result words
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic                          mux_enable,
	output logic                          mux_select,
	output sbuod_pkg::event_t             change_event,
	output logic                          poll_ignored,
	// configuration writes
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  sbuod_pkg::cfg_idx_t     cfg_index,
	input  wire  [15:0]                   cfg_data
);

	// configuration
	sbuod_pkg::sample_t low_thr_q;
	sbuod_pkg::sample_t high_thr_q;
	sbuod_pkg::count_t  settle_q;

	// tracking state
	logic                  enabled_q;
	sbuod_pkg::count_t     seen_count_q;
	sbuod_pkg::pattern_t   last_pattern_q;
	logic                  orientation_q;
	logic                  select_q;

	// input stage
	logic                  valid_s1;
	sbuod_pkg::sample_t    line1_s1;
	sbuod_pkg::sample_t    line2_s1;
	logic                  err_s1;

	// result stage
	logic                  valid_s2;
	logic                  mux_enable_s2;
	logic                  mux_select_s2;
	sbuod_pkg::event_t     event_s2;
	logic                  ignored_s2;

	logic out_free;
	logic s1_free;
	logic advance;

	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign s1_free  = !valid_s1 || out_free;
	assign in_stall = !s1_free;
	assign cfg_ready = 1'b1;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q  <= sbuod_pkg::LOW_THR_RESET;
			high_thr_q <= sbuod_pkg::HIGH_THR_RESET;
			settle_q   <= sbuod_pkg::SETTLE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sbuod_pkg::REG_LOW_THRESHOLD:  low_thr_q  <= cfg_data;
				sbuod_pkg::REG_HIGH_THRESHOLD: high_thr_q <= cfg_data;
				sbuod_pkg::REG_SETTLE_POLLS:   settle_q   <= cfg_data[sbuod_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- input register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			line1_s1 <= line1_sample;
			line2_s1 <= line2_sample;
			err_s1   <= sample_error;
		end
	end

	// ---------------- pattern classify and update ----------------
	logic                l1_high, l1_low, l2_high, l2_low;
	sbuod_pkg::pattern_t pat;
	sbuod_pkg::count_t   count_nxt;
	logic                orient_nxt;
	logic                fire;
	logic                enabled_nxt;
	logic                select_nxt;
	sbuod_pkg::event_t   event_nxt;

	always_comb begin
		l1_high = line1_s1 > high_thr_q;
		l1_low  = line1_s1 < low_thr_q;
		l2_high = line2_s1 > high_thr_q;
		l2_low  = line2_s1 < low_thr_q;

		// flipped test wins when both connect tests hold
		if (!enabled_q && l1_high && l2_low)
			pat = sbuod_pkg::PAT_FLIP;
		else if (!enabled_q && l2_high && l1_low)
			pat = sbuod_pkg::PAT_DIRECT;
		else if (enabled_q && l1_low && l2_low)
			pat = sbuod_pkg::PAT_DISCONNECT;
		else
			pat = sbuod_pkg::PAT_OTHER;

		orient_nxt = orientation_q;
		if (pat == sbuod_pkg::PAT_FLIP && last_pattern_q != sbuod_pkg::PAT_FLIP)
			orient_nxt = sbuod_pkg::ORIENT_FLIPPED;
		else if (pat == sbuod_pkg::PAT_DIRECT && last_pattern_q != sbuod_pkg::PAT_DIRECT)
			orient_nxt = sbuod_pkg::ORIENT_DIRECT;

		if (pat == sbuod_pkg::PAT_OTHER || pat != last_pattern_q)
			count_nxt = '0;
		else if (seen_count_q != sbuod_pkg::COUNT_MAX)
			count_nxt = seen_count_q + 4'd1;
		else
			count_nxt = seen_count_q;

		fire        = count_nxt > settle_q;
		enabled_nxt = enabled_q;
		select_nxt  = select_q;
		event_nxt   = sbuod_pkg::EV_NONE;
		if (fire) begin
			if (enabled_q) begin
				enabled_nxt = 1'b0;
				event_nxt   = sbuod_pkg::EV_DISCONNECT;
			end else begin
				enabled_nxt = 1'b1;
				select_nxt  = orient_nxt;
				event_nxt   = sbuod_pkg::EV_CONNECT;
			end
		end
	end

	// state only moves on an unflagged word leaving the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q      <= 1'b0;
			seen_count_q   <= '0;
			last_pattern_q <= sbuod_pkg::PAT_DISCONNECT;
			orientation_q  <= sbuod_pkg::ORIENT_FLIPPED;
			select_q       <= 1'b0;
		end else if (advance && !err_s1) begin
			enabled_q      <= enabled_nxt;
			seen_count_q   <= count_nxt;
			last_pattern_q <= pat;
			orientation_q  <= orient_nxt;
			select_q       <= select_nxt;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (err_s1) begin
				mux_enable_s2 <= enabled_q;
				mux_select_s2 <= select_q;
				event_s2      <= sbuod_pkg::EV_NONE;
				ignored_s2    <= 1'b1;
			end else begin
				mux_enable_s2 <= enabled_nxt;
				mux_select_s2 <= select_nxt;
				event_s2      <= event_nxt;
				ignored_s2    <= 1'b0;
			end
		end
	end

	assign out_valid    = valid_s2;
	assign mux_enable   = mux_enable_s2;
	assign mux_select   = mux_select_s2;
	assign change_event = event_s2;
	assign poll_ignored = ignored_s2;

	// ---------------- assertions ----------------
	a_connect_on_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(enabled_q) |-> (valid_s2 && event_s2 == sbuod_pkg::EV_CONNECT))
		else $error("mux enabled without a connect word");

	a_disconnect_on_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(enabled_q) |-> (valid_s2 && event_s2 == sbuod_pkg::EV_DISCONNECT))
		else $error("mux disabled without a disconnect word");

	a_ignored_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ignored_s2) |-> (event_s2 == sbuod_pkg::EV_NONE))
		else $error("flagged poll reported a change");

	a_other_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(last_pattern_q == sbuod_pkg::PAT_OTHER) |-> (seen_count_q == '0))
		else $error("count not cleared on other pattern");

	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(enabled_q) && $stable(select_q) && $stable(seen_count_q)))
		else $error("tracking state moved without a word");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the sideband orientation detector
// Polls the block with directed and random sample pairs under several register
// settings. A local copy of the debounce logic predicts each result word, which
// is then checked field by field. Random idling is applied on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	localparam sbuod_pkg::cfg_idx_t REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_POLLS = 155;

	typedef struct packed {
		sbuod_pkg::sample_t s1;
		sbuod_pkg::sample_t s2;
		logic               err;
	} poll_t;

	typedef struct packed {
		logic              en;
		logic              sel;
		sbuod_pkg::event_t ev;
		logic              ign;
	} mux_status_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	sbuod_pkg::sample_t  line1_sample = '0;
	sbuod_pkg::sample_t  line2_sample = '0;
	logic                sample_error = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                mux_enable;
	logic                mux_select;
	sbuod_pkg::event_t   change_event;
	logic                poll_ignored;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	sbuod_pkg::cfg_idx_t cfg_index = '0;
	logic [15:0]         cfg_data = '0;

	poll_t       poll_q[$];
	mux_status_t mux_status_q[$];
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          cyc_count = 0;
	bit          failed = 1'b0;

	// detector copy: registers and tracking state
	sbuod_pkg::sample_t  thr_low = sbuod_pkg::LOW_THR_RESET;
	sbuod_pkg::sample_t  thr_high = sbuod_pkg::HIGH_THR_RESET;
	sbuod_pkg::count_t   settle = sbuod_pkg::SETTLE_RESET;
	logic                det_enabled = 1'b0;
	sbuod_pkg::count_t   det_count = '0;
	sbuod_pkg::pattern_t det_pattern = sbuod_pkg::PAT_DISCONNECT;
	logic                det_orient = sbuod_pkg::ORIENT_FLIPPED;
	logic                det_select = sbuod_pkg::ORIENT_FLIPPED;

	sbu_orientation_detector u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.line1_sample (line1_sample),
		.line2_sample (line2_sample),
		.sample_error (sample_error),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mux_enable   (mux_enable),
		.mux_select   (mux_select),
		.change_event (change_event),
		.poll_ignored (poll_ignored),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc_count <= cyc_count + 1;
		if (cyc_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic predict_mux(input poll_t p);
		sbuod_pkg::pattern_t pat;
		mux_status_t         r;
		r = '{det_enabled, det_select, sbuod_pkg::EV_NONE, 1'b1};
		if (!p.err) begin
			if (!det_enabled && p.s1 > thr_high && p.s2 < thr_low)
				pat = sbuod_pkg::PAT_FLIP;
			else if (!det_enabled && p.s2 > thr_high && p.s1 < thr_low)
				pat = sbuod_pkg::PAT_DIRECT;
			else if (det_enabled && p.s1 < thr_low && p.s2 < thr_low)
				pat = sbuod_pkg::PAT_DISCONNECT;
			else
				pat = sbuod_pkg::PAT_OTHER;
			// orientation is latched when a connect pattern first shows up
			if (pat == sbuod_pkg::PAT_FLIP && det_pattern != sbuod_pkg::PAT_FLIP)
				det_orient = sbuod_pkg::ORIENT_FLIPPED;
			if (pat == sbuod_pkg::PAT_DIRECT && det_pattern != sbuod_pkg::PAT_DIRECT)
				det_orient = sbuod_pkg::ORIENT_DIRECT;
			if (pat == sbuod_pkg::PAT_OTHER || det_pattern != pat)
				det_count = '0;
			else if (det_count != sbuod_pkg::COUNT_MAX)
				det_count = det_count + 4'd1;
			det_pattern = pat;
			r.ev = sbuod_pkg::EV_NONE;
			if (det_count > settle) begin
				if (det_enabled) begin
					det_enabled = 1'b0;
					r.ev = sbuod_pkg::EV_DISCONNECT;
				end else begin
					det_select = det_orient;
					det_enabled = 1'b1;
					r.ev = sbuod_pkg::EV_CONNECT;
				end
			end
			r.en = det_enabled;
			r.sel = det_select;
			r.ign = 1'b0;
		end
		mux_status_q.push_back(r);
	endtask

	// poll driver
	always @(posedge clk) begin
		poll_t p;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_mux('{line1_sample, line2_sample, sample_error});
			if (!in_valid || !in_stall) begin
				if (poll_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					p = poll_q.pop_front();
					in_valid <= 1'b1;
					line1_sample <= p.s1;
					line2_sample <= p.s2;
					sample_error <= p.err;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		mux_status_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (mux_status_q.size() == 0) begin
					$error("result word with none pending");
					failed = 1'b1;
				end else begin
					e = mux_status_q.pop_front();
					if (mux_enable !== e.en) begin
						$error("mux_enable: expected %0d, actual %0d", e.en, mux_enable);
						failed = 1'b1;
					end
					if (mux_select !== e.sel) begin
						$error("mux_select: expected %0d, actual %0d", e.sel, mux_select);
						failed = 1'b1;
					end
					if (change_event !== e.ev) begin
						$error("change_event: expected %0d, actual %0d", e.ev, change_event);
						failed = 1'b1;
					end
					if (poll_ignored !== e.ign) begin
						$error("poll_ignored: expected %0d, actual %0d", e.ign, poll_ignored);
						failed = 1'b1;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	task automatic reg_write(input sbuod_pkg::cfg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (idx)
			sbuod_pkg::REG_LOW_THRESHOLD:  thr_low = val;
			sbuod_pkg::REG_HIGH_THRESHOLD: thr_high = val;
			sbuod_pkg::REG_SETTLE_POLLS:   settle = val[sbuod_pkg::COUNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (!(poll_q.size() == 0 && !in_valid && mux_status_q.size() == 0))
			@(negedge clk);
	endtask

	task automatic add_poll(input sbuod_pkg::sample_t s1, input sbuod_pkg::sample_t s2,
		input logic err);
		poll_q.push_back('{s1, s2, err});
	endtask

	function automatic sbuod_pkg::sample_t line_high();
		if (thr_high == 16'hFFFF)
			return sbuod_pkg::sample_t'($urandom_range(0, 65535));
		return sbuod_pkg::sample_t'($urandom_range(65535, int'(thr_high) + 1));
	endfunction

	function automatic sbuod_pkg::sample_t line_low();
		if (thr_low == 16'h0000)
			return sbuod_pkg::sample_t'($urandom_range(0, 65535));
		return sbuod_pkg::sample_t'($urandom_range(int'(thr_low) - 1, 0));
	endfunction

	// mostly connect / disconnect runs with random content, some noise
	task automatic gen_polls(input int n);
		int                  made;
		int                  run;
		int                  k;
		bit                  want_connect;
		sbuod_pkg::pattern_t pat;
		logic                err;
		made = 0;
		want_connect = 1'b1;
		while (made < n) begin
			if ($urandom_range(0, 99) < 80) begin
				if (want_connect)
					pat = ($urandom_range(0, 1) != 0) ? sbuod_pkg::PAT_FLIP
						: sbuod_pkg::PAT_DIRECT;
				else
					pat = sbuod_pkg::PAT_DISCONNECT;
				want_connect = !want_connect;
				k = $urandom_range(0, 99);
				if (k < 10)
					run = $urandom_range(16, 20);
				else if (k < 75)
					run = $urandom_range(int'(settle) + 2, int'(settle) + 4);
				else
					run = $urandom_range(1, int'(settle) + 1);
				for (k = 0; k < run; k++) begin
					err = ($urandom_range(0, 15) == 0);
					case (pat)
						sbuod_pkg::PAT_FLIP:   add_poll(line_high(), line_low(), err);
						sbuod_pkg::PAT_DIRECT: add_poll(line_low(), line_high(), err);
						default:               add_poll(line_low(), line_low(), err);
					endcase
				end
				made += run;
			end else begin
				add_poll(sbuod_pkg::sample_t'($urandom_range(0, 65535)),
					sbuod_pkg::sample_t'($urandom_range(0, 65535)),
					1'($urandom_range(0, 1)));
				made++;
			end
		end
	endtask

	initial begin
		int mode;
		int c;
		int p;
		int settle_tbl[9];

		settle_tbl = '{0, 15, 2, 14, 1, 5, 3, 7, 4};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// default registers: no pattern can match
		@(negedge clk);
		add_poll(16'h0000, 16'h0000, 1'b0);
		add_poll(16'hFFFF, 16'hFFFF, 1'b0);
		add_poll(16'hFFFF, 16'h0000, 1'b1);
		wait_idle();

		reg_write(sbuod_pkg::REG_LOW_THRESHOLD, 16'h4000);
		reg_write(sbuod_pkg::REG_HIGH_THRESHOLD, 16'hC000);
		reg_write(sbuod_pkg::REG_SETTLE_POLLS, 16'h0000);
		@(negedge clk);
		add_poll(16'hFFFF, 16'h0000, 1'b0);
		add_poll(16'hFFFF, 16'h0000, 1'b0);
		// same pattern right after connect is no longer a request
		add_poll(16'hFFFF, 16'h0000, 1'b0);
		add_poll(16'h0000, 16'h0000, 1'b0);
		add_poll(16'h0000, 16'h0000, 1'b0);
		add_poll(16'h0000, 16'hFFFF, 1'b0);
		add_poll(16'h0000, 16'hFFFF, 1'b0);
		add_poll(16'h0000, 16'h0000, 1'b1);
		// flagged poll between two disconnect polls keeps the count
		add_poll(16'h0000, 16'h0000, 1'b0);
		add_poll(16'h0000, 16'h0000, 1'b1);
		add_poll(16'h0000, 16'h0000, 1'b0);
		wait_idle();

		// crossed thresholds: both request tests hold, flipped wins
		reg_write(sbuod_pkg::REG_LOW_THRESHOLD, 16'hFFFF);
		reg_write(sbuod_pkg::REG_HIGH_THRESHOLD, 16'h0000);
		reg_write(sbuod_pkg::REG_SETTLE_POLLS, 16'h0001);
		reg_write(REG_UNUSED, 16'h0000);
		@(negedge clk);
		add_poll(16'h0005, 16'h0005, 1'b0);
		add_poll(16'h0005, 16'h0005, 1'b0);
		add_poll(16'h0005, 16'h0005, 1'b0);
		wait_idle();

		for (mode = 0; mode < 3; mode++) begin
			@(negedge clk);
			tx_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 67 : 0;
			rx_idle_pct = (mode == 0) ? 67 : (mode == 1) ? 15 : 0;
			for (c = 0; c < 3; c++) begin
				p = mode * 3 + c;
				if (p == 4) begin
					reg_write(sbuod_pkg::REG_LOW_THRESHOLD, 16'hFFFF);
					reg_write(sbuod_pkg::REG_HIGH_THRESHOLD, 16'h0000);
				end else if (p == 7) begin
					reg_write(sbuod_pkg::REG_LOW_THRESHOLD, 16'h0000);
					reg_write(sbuod_pkg::REG_HIGH_THRESHOLD, 16'hFFFF);
				end else begin
					reg_write(sbuod_pkg::REG_LOW_THRESHOLD, 16'($urandom_range(1, 65535)));
					reg_write(sbuod_pkg::REG_HIGH_THRESHOLD, 16'($urandom_range(0, 65534)));
				end
				// upper data bits of the settle register are dropped
				reg_write(sbuod_pkg::REG_SETTLE_POLLS,
					16'(($urandom_range(0, 4095) << 4) | settle_tbl[p]));
				if (p == 0)
					reg_write(REG_UNUSED, 16'($urandom_range(0, 65535)));
				@(negedge clk);
				gen_polls(PHASE_POLLS);
				wait_idle();
			end
		end

		repeat (8) @(posedge clk);
		if (!failed && mux_status_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
